/* src/kpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared widths, strides, register indexes and beat types of the keypoint
// proposal decoder.
// ----------------------------------------------------------------------------
package kpd_pkg;

    // Field widths
    localparam int DATA_W       = 16;  // Q8.8 tensor values and Q12.4 corners
    localparam int NET_W        = 11;  // net_width / net_height
    localparam int SCALE_W      = 16;  // inv_scale, unsigned Q4.12
    localparam int COLOR_CNT_W  = 4;
    localparam int CLASS_CNT_W  = 5;
    localparam int COLOR_SLOT_W = 3;
    localparam int CLASS_SLOT_W = 4;
    localparam int ANCHOR_W     = 15;
    localparam int POS_W        = 6;   // element position inside a record
    localparam int LEN_W        = POS_W + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CORNERS      = 4;

    // Grid walk: a column can reach net_width / 8 - 1 at stride eight
    localparam int GRID_W   = NET_W;
    localparam int STRIDE_W = 9;
    localparam int EDGE_W   = NET_W + 1;
    localparam int LEVELS   = 3;
    localparam int LEVEL_W  = 2;

    // Fixed settings of the head
    localparam int APEX_COUNT_DEF = 4;
    localparam int MAX_COLORS     = 8;
    localparam int MAX_CLASSES    = 16;
    localparam int STRIDE_SMALL   = 8;
    localparam int STRIDE_MID     = 16;
    localparam int STRIDE_LARGE   = 32;

    // Result beat: corners, class, color, confidence, anchor, byte padding
    localparam int OUT_BITS   = 2 * CORNERS * DATA_W + CLASS_SLOT_W + COLOR_SLOT_W
                                + DATA_W + ANCHOR_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_NET_WIDTH       = 3'd1,
        REG_NET_HEIGHT      = 3'd2,
        REG_INV_SCALE_X     = 3'd3,
        REG_INV_SCALE_Y     = 3'd4,
        REG_COLOR_COUNT     = 3'd5,
        REG_CLASS_COUNT     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [DATA_W-1:0]      score_threshold;   // signed Q8.8
        logic [NET_W-1:0]       net_width;
        logic [NET_W-1:0]       net_height;
        logic [SCALE_W-1:0]     inv_scale_x;
        logic [SCALE_W-1:0]     inv_scale_y;
        logic [COLOR_CNT_W-1:0] color_count;
        logic [CLASS_CNT_W-1:0] class_count;
    } cfg_t;

    // One finished anchor, handed from the record walker to the scaler
    typedef struct packed {
        logic [GRID_W-1:0]       grid_x;
        logic [GRID_W-1:0]       grid_y;
        logic [STRIDE_W-1:0]     stride;
        logic [DATA_W-1:0]       box;          // signed
        logic [DATA_W-1:0]       class_score;  // signed
        logic [DATA_W-1:0]       color_score;  // signed
        logic [CLASS_SLOT_W-1:0] class_slot;
        logic [COLOR_SLOT_W-1:0] color_slot;
        logic [ANCHOR_W-1:0]     anchor;
    } launch_t;

    // Stride of a level
    function automatic logic [STRIDE_W-1:0] stride_of(input logic [LEVEL_W-1:0] level);
        logic [STRIDE_W-1:0] s;
        case (level)
            2'd1:    s = STRIDE_W'(STRIDE_MID);
            2'd2:    s = STRIDE_W'(STRIDE_LARGE);
            default: s = STRIDE_W'(STRIDE_SMALL);
        endcase
        return s;
    endfunction

    // Lowest non-empty level, level 0 when all are empty
    function automatic logic [LEVEL_W-1:0] first_level(input logic [LEVELS-1:0] empty);
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (!empty[k]) begin
                lvl = LEVEL_W'(k);
            end
        end
        return lvl;
    endfunction

endpackage

/* src/kpd_record.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_record
// Walks the anchor grid, places each tensor beat in its record, keeps the
// keypoint offsets and running argmax scores, and registers a finished
// anchor that passes the box threshold into the launch register.
// ----------------------------------------------------------------------------
module kpd_record #(
    parameter int APEX_COUNT = kpd_pkg::APEX_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kpd_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [kpd_pkg::DATA_W-1:0] in_value,
    input  logic                          in_start,
    output logic                          launch_valid,
    input  logic                          launch_ready,
    output kpd_pkg::launch_t              launch,
    output logic signed [kpd_pkg::DATA_W-1:0] launch_kp [2*APEX_COUNT]
);
    import kpd_pkg::*;

    localparam int KP_LEN   = 2 * APEX_COUNT;
    localparam int KP_IDX_W = $clog2(KP_LEN);

    // Walk state
    logic [POS_W-1:0]    pos_reg,      pos_next;
    logic [GRID_W-1:0]   col_reg,      col_next;
    logic [GRID_W-1:0]   row_reg,      row_next;
    logic [LEVEL_W-1:0]  level_reg,    level_next;
    logic [ANCHOR_W-1:0] anchor_reg,   anchor_next;
    logic [EDGE_W-1:0]   col_edge_reg, col_edge_next;  // (col + 2) * stride
    logic [EDGE_W-1:0]   row_edge_reg, row_edge_next;  // (row + 2) * stride

    // Record contents
    logic signed [DATA_W-1:0] kp_reg [KP_LEN];
    logic signed [DATA_W-1:0] box_reg;
    logic signed [DATA_W-1:0] color_best_reg, color_best_next;
    logic [COLOR_SLOT_W-1:0]  color_slot_reg, color_slot_next;
    logic signed [DATA_W-1:0] class_best_reg, class_best_next;
    logic [CLASS_SLOT_W-1:0]  class_slot_reg, class_slot_next;

    // Launch register
    logic                     lvalid_reg, lvalid_next;
    launch_t                  launch_reg;
    logic signed [DATA_W-1:0] lkp_reg [KP_LEN];

    // Beat decode
    logic                    accept;
    logic [LEVELS-1:0]       empty;
    logic [LEVEL_W-1:0]      lvl_first;
    logic [POS_W-1:0]        eff_pos;
    logic [GRID_W-1:0]       eff_col, eff_row;
    logic [LEVEL_W-1:0]      eff_level;
    logic [ANCHOR_W-1:0]     eff_anchor;
    logic [EDGE_W-1:0]       eff_col_edge, eff_row_edge;
    logic [STRIDE_W-1:0]     s_cur, s_new;
    logic [COLOR_CNT_W-1:0]  nc;
    logic [CLASS_CNT_W-1:0]  nk;
    logic [LEN_W-1:0]        p7, color_end, rec_len, slot_j;
    logic                    kp_we, box_we, last, emit;
    logic [LEVEL_W-1:0]      lvl_after;
    logic                    lvl_found;

    assign accept   = in_valid && in_ready;
    assign in_ready = !lvalid_reg || launch_ready;

    // Level occupancy from the current net size
    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            empty[l] = (NET_W'(stride_of(LEVEL_W'(l))) > cfg.net_width) ||
                       (NET_W'(stride_of(LEVEL_W'(l))) > cfg.net_height);
        end
    end
    assign lvl_first = first_level(empty);

    // Counts clamped to the supported range
    always_comb begin
        if (cfg.color_count == '0) begin
            nc = COLOR_CNT_W'(1);
        end else if (cfg.color_count > COLOR_CNT_W'(MAX_COLORS)) begin
            nc = COLOR_CNT_W'(MAX_COLORS);
        end else begin
            nc = cfg.color_count;
        end
        if (cfg.class_count == '0) begin
            nk = CLASS_CNT_W'(1);
        end else if (cfg.class_count > CLASS_CNT_W'(MAX_CLASSES)) begin
            nk = CLASS_CNT_W'(MAX_CLASSES);
        end else begin
            nk = cfg.class_count;
        end
    end

    // Frame start restarts the walk at this beat
    always_comb begin
        if (in_start) begin
            eff_pos      = '0;
            eff_col      = '0;
            eff_row      = '0;
            eff_level    = lvl_first;
            eff_anchor   = '0;
            eff_col_edge = EDGE_W'({stride_of(lvl_first), 1'b0});
            eff_row_edge = EDGE_W'({stride_of(lvl_first), 1'b0});
        end else begin
            eff_pos      = pos_reg;
            eff_col      = col_reg;
            eff_row      = row_reg;
            eff_level    = level_reg;
            eff_anchor   = anchor_reg;
            eff_col_edge = col_edge_reg;
            eff_row_edge = row_edge_reg;
        end
    end

    assign s_cur     = stride_of(eff_level);
    assign p7        = LEN_W'(eff_pos);
    assign color_end = LEN_W'(KP_LEN + 1) + LEN_W'(nc);
    assign rec_len   = color_end + LEN_W'(nk);
    assign last      = (p7 + LEN_W'(1)) >= rec_len;
    assign kp_we     = p7 < LEN_W'(KP_LEN);
    assign box_we    = p7 == LEN_W'(KP_LEN);
    assign emit      = accept && last && (box_reg >= $signed(cfg.score_threshold));

    // Running argmax, the first slot wins a tie
    always_comb begin
        color_best_next = color_best_reg;
        color_slot_next = color_slot_reg;
        class_best_next = class_best_reg;
        class_slot_next = class_slot_reg;
        slot_j          = '0;
        if (kp_we) begin
            slot_j = '0;
        end else if (box_we) begin
            color_best_next = {1'b1, {(DATA_W-1){1'b0}}};
            class_best_next = {1'b1, {(DATA_W-1){1'b0}}};
            color_slot_next = '0;
            class_slot_next = '0;
        end else if (p7 < color_end) begin
            slot_j = p7 - LEN_W'(KP_LEN + 1);
            if (slot_j == '0 || in_value > color_best_reg) begin
                color_best_next = in_value;
                color_slot_next = slot_j[COLOR_SLOT_W-1:0];
            end
        end else begin
            slot_j = p7 - color_end;
            if (slot_j == '0 || in_value > class_best_reg) begin
                class_best_next = in_value;
                class_slot_next = slot_j[CLASS_SLOT_W-1:0];
            end
        end
    end

    // Level after the current one; wrap when none is left
    always_comb begin
        lvl_after = lvl_first;
        lvl_found = 1'b0;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (LEVEL_W'(k) > eff_level && !empty[k]) begin
                lvl_after = LEVEL_W'(k);
                lvl_found = 1'b1;
            end
        end
    end
    assign s_new = stride_of(lvl_after);

    // Grid advance at the end of a record
    always_comb begin
        pos_next      = eff_pos + POS_W'(1);
        col_next      = eff_col;
        row_next      = eff_row;
        level_next    = eff_level;
        anchor_next   = eff_anchor;
        col_edge_next = eff_col_edge;
        row_edge_next = eff_row_edge;
        if (last) begin
            pos_next    = '0;
            anchor_next = eff_anchor + ANCHOR_W'(1);
            if (eff_col_edge > EDGE_W'(cfg.net_width)) begin
                col_next      = '0;
                col_edge_next = EDGE_W'({s_cur, 1'b0});
                if (eff_row_edge > EDGE_W'(cfg.net_height)) begin
                    row_next      = '0;
                    level_next    = lvl_after;
                    col_edge_next = EDGE_W'({s_new, 1'b0});
                    row_edge_next = EDGE_W'({s_new, 1'b0});
                    if (!lvl_found) begin
                        anchor_next = '0;
                    end
                end else begin
                    row_next      = eff_row + GRID_W'(1);
                    row_edge_next = eff_row_edge + EDGE_W'(s_cur);
                end
            end else begin
                col_next      = eff_col + GRID_W'(1);
                col_edge_next = eff_col_edge + EDGE_W'(s_cur);
            end
        end
    end

    assign lvalid_next = emit ? 1'b1 : (launch_ready ? 1'b0 : lvalid_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            level_reg      <= '0;
            anchor_reg     <= '0;
            col_edge_reg   <= EDGE_W'(2 * STRIDE_SMALL);
            row_edge_reg   <= EDGE_W'(2 * STRIDE_SMALL);
            color_slot_reg <= '0;
            class_slot_reg <= '0;
            lvalid_reg     <= 1'b0;
        end else begin
            lvalid_reg <= lvalid_next;
            if (accept) begin
                pos_reg        <= pos_next;
                col_reg        <= col_next;
                row_reg        <= row_next;
                level_reg      <= level_next;
                anchor_reg     <= anchor_next;
                col_edge_reg   <= col_edge_next;
                row_edge_reg   <= row_edge_next;
                color_slot_reg <= color_slot_next;
                class_slot_reg <= class_slot_next;
            end
        end
    end

    // Record payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (kp_we) begin
                kp_reg[KP_IDX_W'(eff_pos)] <= in_value;
            end
            if (box_we) begin
                box_reg <= in_value;
            end
            color_best_reg <= color_best_next;
            class_best_reg <= class_best_next;
        end
    end

    // Launch payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            launch_reg.grid_x      <= eff_col;
            launch_reg.grid_y      <= eff_row;
            launch_reg.stride      <= s_cur;
            launch_reg.box         <= box_reg;
            launch_reg.class_score <= class_best_next;
            launch_reg.color_score <= color_best_next;
            launch_reg.class_slot  <= class_slot_next;
            launch_reg.color_slot  <= color_slot_next;
            launch_reg.anchor      <= eff_anchor;
            lkp_reg                <= kp_reg;
        end
    end

    assign launch_valid = lvalid_reg;
    assign launch       = launch_reg;
    assign launch_kp    = lkp_reg;

endmodule

/* src/kpd_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_scale
// Three-stage pipeline that turns a launched anchor into source-pixel
// corners and a confidence: stride product, scale product, then rounding
// and saturation into the result register. Each stage holds its beat
// until the next one has room.
// ----------------------------------------------------------------------------
module kpd_scale #(
    parameter int APEX_COUNT = kpd_pkg::APEX_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [kpd_pkg::SCALE_W-1:0]        inv_scale_x,
    input  logic [kpd_pkg::SCALE_W-1:0]        inv_scale_y,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  kpd_pkg::launch_t                   launch,
    input  logic signed [kpd_pkg::DATA_W-1:0]  launch_kp [2*APEX_COUNT],
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [kpd_pkg::DATA_W-1:0]  out_kp [2*APEX_COUNT],
    output logic [kpd_pkg::CLASS_SLOT_W-1:0]   out_class,
    output logic [kpd_pkg::COLOR_SLOT_W-1:0]   out_color,
    output logic [kpd_pkg::DATA_W-1:0]         out_conf,
    output logic [kpd_pkg::ANCHOR_W-1:0]       out_anchor
);
    import kpd_pkg::*;

    localparam int KP_LEN = 2 * APEX_COUNT;
    localparam int SUM_W  = GRID_W + 8 + 2;           // offset + grid * 256
    localparam int P1_W   = SUM_W + STRIDE_W + 1;     // times stride
    localparam int P2_W   = P1_W + SCALE_W + 1;       // times inv_scale
    localparam int RND_W  = P2_W + 1;
    localparam int CS_W   = DATA_W + 1;               // class + color
    localparam int CP_W   = DATA_W + CS_W;            // box * (class + color)

    localparam logic signed [RND_W-1:0] KP_HALF = RND_W'(32768);
    localparam logic signed [RND_W-1:0] KP_MAX  = RND_W'(32767);
    localparam logic signed [RND_W-1:0] KP_MIN  = -RND_W'(32768);
    localparam logic signed [CP_W:0]    CF_HALF = (CP_W+1)'(256);
    localparam logic signed [CP_W:0]    CF_MAX  = (CP_W+1)'(65535);

    // Stage valids and readiness
    logic v1_reg, v2_reg, vo_reg;
    logic r1, r2, ro;

    // Stage 1: offset plus grid, times stride; box times score sum
    logic signed [SUM_W-1:0]  sum      [KP_LEN];
    logic signed [P1_W-1:0]   p1_reg   [KP_LEN];
    logic signed [CS_W-1:0]   cs;
    logic signed [CP_W-1:0]   cp1_reg;
    logic [CLASS_SLOT_W-1:0]  class1_reg;
    logic [COLOR_SLOT_W-1:0]  color1_reg;
    logic [ANCHOR_W-1:0]      anchor1_reg;

    // Stage 2: times inverse scale; confidence rounded
    logic signed [P2_W-1:0]   p2_reg   [KP_LEN];
    logic signed [CP_W:0]     cf_round;
    logic [DATA_W-1:0]        conf_next;
    logic [DATA_W-1:0]        conf2_reg;
    logic [CLASS_SLOT_W-1:0]  class2_reg;
    logic [COLOR_SLOT_W-1:0]  color2_reg;
    logic [ANCHOR_W-1:0]      anchor2_reg;

    // Result register
    logic signed [RND_W-1:0]  kp_round [KP_LEN];
    logic signed [DATA_W-1:0] kp_next  [KP_LEN];
    logic signed [DATA_W-1:0] kpo_reg  [KP_LEN];
    logic [DATA_W-1:0]        confo_reg;
    logic [CLASS_SLOT_W-1:0]  classo_reg;
    logic [COLOR_SLOT_W-1:0]  coloro_reg;
    logic [ANCHOR_W-1:0]      anchoro_reg;

    assign ro       = !vo_reg || out_ready;
    assign r2       = !v2_reg || ro;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (ro) begin
                vo_reg <= v2_reg;
            end
        end
    end

    // Stage 1 logic
    always_comb begin
        for (int i = 0; i < KP_LEN; i++) begin
            if (i % 2 == 0) begin
                sum[i] = SUM_W'(launch_kp[i]) + $signed({2'b00, launch.grid_x, 8'h00});
            end else begin
                sum[i] = SUM_W'(launch_kp[i]) + $signed({2'b00, launch.grid_y, 8'h00});
            end
        end
        cs = CS_W'($signed(launch.class_score)) + CS_W'($signed(launch.color_score));
    end

    always_ff @(posedge aclk) begin
        if (r1) begin
            for (int i = 0; i < KP_LEN; i++) begin
                p1_reg[i] <= sum[i] * $signed({1'b0, launch.stride});
            end
            cp1_reg     <= $signed(launch.box) * cs;
            class1_reg  <= launch.class_slot;
            color1_reg  <= launch.color_slot;
            anchor1_reg <= launch.anchor;
        end
    end

    // Stage 2 logic: confidence rounded half up, clamped to Q8.8 unsigned
    always_comb begin
        cf_round = ((CP_W+1)'(cp1_reg) + CF_HALF) >>> 9;
        if (cf_round < 0) begin
            conf_next = '0;
        end else if (cf_round > CF_MAX) begin
            conf_next = {DATA_W{1'b1}};
        end else begin
            conf_next = cf_round[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (r2) begin
            for (int i = 0; i < KP_LEN; i++) begin
                if (i % 2 == 0) begin
                    p2_reg[i] <= p1_reg[i] * $signed({1'b0, inv_scale_x});
                end else begin
                    p2_reg[i] <= p1_reg[i] * $signed({1'b0, inv_scale_y});
                end
            end
            conf2_reg   <= conf_next;
            class2_reg  <= class1_reg;
            color2_reg  <= color1_reg;
            anchor2_reg <= anchor1_reg;
        end
    end

    // Result logic: Q12.4 rounded half up and saturated
    always_comb begin
        for (int i = 0; i < KP_LEN; i++) begin
            kp_round[i] = (RND_W'(p2_reg[i]) + KP_HALF) >>> 16;
            if (kp_round[i] > KP_MAX) begin
                kp_next[i] = {1'b0, {(DATA_W-1){1'b1}}};
            end else if (kp_round[i] < KP_MIN) begin
                kp_next[i] = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                kp_next[i] = kp_round[i][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ro) begin
            kpo_reg     <= kp_next;
            confo_reg   <= conf2_reg;
            classo_reg  <= class2_reg;
            coloro_reg  <= color2_reg;
            anchoro_reg <= anchor2_reg;
        end
    end

    assign out_valid  = vo_reg;
    assign out_kp     = kpo_reg;
    assign out_conf   = confo_reg;
    assign out_class  = classo_reg;
    assign out_color  = coloro_reg;
    assign out_anchor = anchoro_reg;

endmodule

/* src/keypoint_proposal_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypoint_proposal_decoder
// Streams a detector head tensor and emits one keypoint proposal for each
// anchor whose box score reaches the threshold.
// ----------------------------------------------------------------------------
// The block takes one tensor element per clock while s_tready is high, in record
// order, and walks the three-level anchor grid by itself; frame_start in tuser
// restarts the walk at that element. After its last element is accepted, an
// anchor's result passes through one launch register, then a stride multiply,
// a scale multiply and a rounding stage, each holding its beat under
// backpressure. The input is stalled whenever the launch register holds an
// anchor that the scaler cannot take, so short stalls on the master side are
// absorbed. Configuration writes are taken at any time and must only happen
// while no element is in flight.
// ----------------------------------------------------------------------------
module keypoint_proposal_decoder #(
    parameter int APEX_COUNT = kpd_pkg::APEX_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Tensor elements
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kpd_pkg::DATA_W-1:0]          s_tdata,   // [15:0] value
    input  logic                                s_tuser,   // [0] frame_start
    // Proposals
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] corner0_x, [31:16] corner0_y, [47:32] corner1_x,
    // [63:48] corner1_y, [79:64] corner2_x, [95:80] corner2_y,
    // [111:96] corner3_x, [127:112] corner3_y, [131:128] class_index,
    // [134:132] color_index, [150:135] confidence, [165:151] anchor_index,
    // [167:166] zero
    output logic [kpd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kpd_pkg::DATA_W-1:0]          cfg_data
);
    import kpd_pkg::*;

    localparam int KP_LEN = 2 * APEX_COUNT;

    cfg_t                     cfg_reg;
    logic                     launch_valid, launch_ready;
    launch_t                  launch;
    logic signed [DATA_W-1:0] launch_kp [KP_LEN];
    logic signed [DATA_W-1:0] out_kp    [KP_LEN];
    logic [CLASS_SLOT_W-1:0]  out_class;
    logic [COLOR_SLOT_W-1:0]  out_color;
    logic [DATA_W-1:0]        out_conf;
    logic [ANCHOR_W-1:0]      out_anchor;
    logic [DATA_W-1:0]        corner_field [2*CORNERS];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.score_threshold <= DATA_W'(128);
            cfg_reg.net_width       <= NET_W'(416);
            cfg_reg.net_height      <= NET_W'(416);
            cfg_reg.inv_scale_x     <= SCALE_W'(4096);
            cfg_reg.inv_scale_y     <= SCALE_W'(4096);
            cfg_reg.color_count     <= COLOR_CNT_W'(4);
            cfg_reg.class_count     <= CLASS_CNT_W'(9);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_SCORE_THRESHOLD: cfg_reg.score_threshold <= cfg_data;
                REG_NET_WIDTH:       cfg_reg.net_width   <= cfg_data[NET_W-1:0];
                REG_NET_HEIGHT:      cfg_reg.net_height  <= cfg_data[NET_W-1:0];
                REG_INV_SCALE_X:     cfg_reg.inv_scale_x <= cfg_data;
                REG_INV_SCALE_Y:     cfg_reg.inv_scale_y <= cfg_data;
                REG_COLOR_COUNT:     cfg_reg.color_count <= cfg_data[COLOR_CNT_W-1:0];
                REG_CLASS_COUNT:     cfg_reg.class_count <= cfg_data[CLASS_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid walk and record capture
    kpd_record #(
        .APEX_COUNT (APEX_COUNT)
    ) u_record (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_value     ($signed(s_tdata)),
        .in_start     (s_tuser),
        .launch_valid (launch_valid),
        .launch_ready (launch_ready),
        .launch       (launch),
        .launch_kp    (launch_kp)
    );

    // Corner scaling and confidence
    kpd_scale #(
        .APEX_COUNT (APEX_COUNT)
    ) u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .inv_scale_x (cfg_reg.inv_scale_x),
        .inv_scale_y (cfg_reg.inv_scale_y),
        .in_valid    (launch_valid),
        .in_ready    (launch_ready),
        .launch      (launch),
        .launch_kp   (launch_kp),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kp      (out_kp),
        .out_class   (out_class),
        .out_color   (out_color),
        .out_conf    (out_conf),
        .out_anchor  (out_anchor)
    );

    // Corners past the apex count read as zero
    for (genvar g = 0; g < 2 * CORNERS; g++) begin : g_corner
        if (g < KP_LEN) begin : g_used
            assign corner_field[g] = out_kp[g];
        end else begin : g_unused
            assign corner_field[g] = '0;
        end
    end

    // Result beat packing
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < 2 * CORNERS; i++) begin
            m_tdata[i*DATA_W +: DATA_W] = corner_field[i];
        end
        m_tdata[2*CORNERS*DATA_W +: CLASS_SLOT_W] = out_class;
        m_tdata[2*CORNERS*DATA_W + CLASS_SLOT_W +: COLOR_SLOT_W] = out_color;
        m_tdata[2*CORNERS*DATA_W + CLASS_SLOT_W + COLOR_SLOT_W +: DATA_W] = out_conf;
        m_tdata[2*CORNERS*DATA_W + CLASS_SLOT_W + COLOR_SLOT_W + DATA_W +: ANCHOR_W] =
            out_anchor;
    end

endmodule

/* src/kpd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_checker
// Port-level checks of the keypoint proposal decoder, bound to the top.
// ----------------------------------------------------------------------------
module kpd_checker #(
    parameter int APEX_COUNT = kpd_pkg::APEX_COUNT_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [kpd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);
    import kpd_pkg::*;

    // Reset empties the pipeline and opens the input
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // Byte padding stays zero, and so does the last corner field with fewer apexes than corners
    a_out_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:OUT_BITS] == '0) &&
                     ((APEX_COUNT >= CORNERS) ||
                      (m_tdata[2*CORNERS*DATA_W-1 -: DATA_W] == '0)))
        else $error("unused result bits set");

    // Configuration writes never wait
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // Input can only stall while a result is pending downstream
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind keypoint_proposal_decoder kpd_checker #(
    .APEX_COUNT (APEX_COUNT)
) u_kpd_checker (.*);

/* sim/keypoint_proposal_decoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypoint_proposal_decoder_test
// Self-checking bench for the keypoint proposal decoder.
// ----------------------------------------------------------------------------
// A queue of tensor elements and register writes is built up front. A clocked
// driver feeds it to the block and, on every accepted element, runs a local
// decoder that walks the anchor grid and predicts the proposals. A clocked
// monitor compares each proposal beat, field by field, with the oldest
// prediction. Both sides insert random waits, with calm stretches between.
// Register writes are only issued once the block has gone quiet.
// ----------------------------------------------------------------------------
module keypoint_proposal_decoder_test;
    import kpd_pkg::*;

    localparam int ITEMS       = 1550;
    localparam int SETTLE      = 12;       // quiet cycles before a register write
    localparam int CYCLE_LIMIT = 200000;
    localparam int KP_LEN      = 2 * APEX_COUNT_DEF;

    // One entry of the stimulus queue: an element or a register write
    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    data;
        logic                 start;
    } feed_t;

    // One proposal, laid out as the low bits of m_tdata
    typedef struct packed {
        logic [ANCHOR_W-1:0]      anchor;
        logic [DATA_W-1:0]        conf;
        logic [COLOR_SLOT_W-1:0]  color;
        logic [CLASS_SLOT_W-1:0]  cls;
        logic [7:0][DATA_W-1:0]   corner;
    } proposal_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data  = '0;

    keypoint_proposal_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    feed_t     feed_q[$];
    proposal_t proposal_q[$];
    int        failures   = 0;
    int        n_items    = 0;
    int        n_sent     = 0;
    int        n_seen     = 0;
    int        beat_gap   = 0;
    int        ready_wait = 0;
    int        quiet      = 0;
    int        cycles     = 0;

    // Decoder registers, reset values
    logic signed [DATA_W-1:0] thr_reg     = 16'sd128;
    int unsigned              width_reg   = 416;
    int unsigned              height_reg  = 416;
    logic [SCALE_W-1:0]       scale_x_reg = 16'd4096;
    logic [SCALE_W-1:0]       scale_y_reg = 16'd4096;
    int unsigned              colors_reg  = 4;
    int unsigned              classes_reg = 9;

    // Decoder walk state
    int unsigned              st_pos    = 0;
    int unsigned              st_col    = 0;
    int unsigned              st_row    = 0;
    int unsigned              st_level  = 0;
    logic [ANCHOR_W-1:0]      st_anchor = '0;
    logic signed [DATA_W-1:0] kp_hold [8];
    logic signed [DATA_W-1:0] box_hold   = '0;
    logic signed [DATA_W-1:0] best_color = '0;
    logic signed [DATA_W-1:0] best_class = '0;
    logic [COLOR_SLOT_W-1:0]  best_color_slot = '0;
    logic [CLASS_SLOT_W-1:0]  best_class_slot = '0;

    // Generator's view of the layout, follows the queued writes
    logic signed [DATA_W-1:0] gen_thr = 16'sd128;
    int unsigned              gen_colors  = 4;
    int unsigned              gen_classes = 9;

    function automatic int unsigned clamp_count(input int unsigned n, input int unsigned top);
        return (n < 1) ? 1 : ((n > top) ? top : n);
    endfunction

    function automatic int pick_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic int unsigned level_stride(input int unsigned l);
        case (l)
            1:       return STRIDE_MID;
            2:       return STRIDE_LARGE;
            default: return STRIDE_SMALL;
        endcase
    endfunction

    function automatic bit level_empty(input int unsigned l);
        return (width_reg / level_stride(l)) == 0 || (height_reg / level_stride(l)) == 0;
    endfunction

    // Keypoint in source pixels, Q12.4, rounded half up and saturated
    function automatic logic [DATA_W-1:0] to_source(input logic signed [DATA_W-1:0] off,
                                                    input int unsigned grid,
                                                    input int unsigned stride,
                                                    input logic [SCALE_W-1:0] inv);
        longint t;
        longint r;
        t = (longint'(off) + longint'(grid) * 256) * longint'(stride) * longint'(inv);
        r = (t + 32768) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[DATA_W-1:0];
    endfunction

    // Move to the first non-empty level from l on; wrap past the last one
    task automatic enter_level(input int unsigned l);
        while (l < LEVELS && level_empty(l)) l++;
        if (l >= LEVELS) begin
            st_anchor = '0;
            l = 0;
            while (l < LEVELS && level_empty(l)) l++;
            if (l >= LEVELS) l = 0;
        end
        st_level = l;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        case (cfg_reg_t'(idx))
            REG_SCORE_THRESHOLD: thr_reg     = data;
            REG_NET_WIDTH:       width_reg   = data[NET_W-1:0];
            REG_NET_HEIGHT:      height_reg  = data[NET_W-1:0];
            REG_INV_SCALE_X:     scale_x_reg = data;
            REG_INV_SCALE_Y:     scale_y_reg = data;
            REG_COLOR_COUNT:     colors_reg  = data[COLOR_CNT_W-1:0];
            REG_CLASS_COUNT:     classes_reg = data[CLASS_CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Predict the effect of one accepted tensor element
    task automatic decode_element(input logic [DATA_W-1:0] value, input logic start);
        logic signed [DATA_W-1:0] v;
        int unsigned nc, nk, len, p, j, s, i;
        longint cv;
        proposal_t r;
        v  = value;
        nc = clamp_count(colors_reg, MAX_COLORS);
        nk = clamp_count(classes_reg, MAX_CLASSES);
        len = KP_LEN + 1 + nc + nk;
        if (start) begin
            st_pos = 0;
            st_col = 0;
            st_row = 0;
            enter_level(0);
            st_anchor = '0;
        end
        p = st_pos;

        // Place the element by the current layout
        if (p < KP_LEN) begin
            kp_hold[p & 7] = v;
        end else if (p == KP_LEN) begin
            box_hold        = v;
            best_color      = 16'sh8000;
            best_class      = 16'sh8000;
            best_color_slot = '0;
            best_class_slot = '0;
        end else if (p < KP_LEN + 1 + nc) begin
            j = p - (KP_LEN + 1);
            if (j == 0 || v > best_color) begin
                best_color      = v;
                best_color_slot = COLOR_SLOT_W'(j);
            end
        end else begin
            j = p - (KP_LEN + 1 + nc);
            if (j == 0 || v > best_class) begin
                best_class      = v;
                best_class_slot = CLASS_SLOT_W'(j);
            end
        end

        // Record done: maybe a proposal, then step the grid
        if (p + 1 >= len) begin
            if (box_hold >= thr_reg) begin
                s = level_stride(st_level);
                r = '0;
                for (i = 0; i < APEX_COUNT_DEF && i < 4; i++) begin
                    r.corner[2*i]   = to_source(kp_hold[(2*i) & 7], st_col, s, scale_x_reg);
                    r.corner[2*i+1] = to_source(kp_hold[(2*i+1) & 7], st_row, s, scale_y_reg);
                end
                r.cls   = best_class_slot;
                r.color = best_color_slot;
                cv = (longint'(box_hold) * (longint'(best_class) + longint'(best_color)) + 256)
                     >>> 9;
                if (cv < 0) cv = 0;
                if (cv > 65535) cv = 65535;
                r.conf   = cv[DATA_W-1:0];
                r.anchor = st_anchor;
                proposal_q.push_back(r);
            end
            st_anchor = st_anchor + 1'b1;
            st_col++;
            if (st_col >= width_reg / level_stride(st_level)) begin
                st_col = 0;
                st_row++;
                if (st_row >= height_reg / level_stride(st_level)) begin
                    st_row = 0;
                    enter_level(st_level + 1);
                end
            end
            st_pos = 0;
        end else begin
            st_pos = (p + 1) & 63;
        end
    endtask

    // Stimulus queue helpers
    task automatic push_element(input logic [DATA_W-1:0] value, input logic start);
        feed_t f;
        f.is_write = 1'b0;
        f.index    = '0;
        f.data     = value;
        f.start    = start;
        feed_q.push_back(f);
        n_items++;
    endtask

    task automatic push_write(input cfg_reg_t idx, input logic [DATA_W-1:0] data);
        feed_t f;
        f.is_write = 1'b1;
        f.index    = idx;
        f.data     = data;
        f.start    = 1'b0;
        feed_q.push_back(f);
        case (idx)
            REG_SCORE_THRESHOLD: gen_thr     = data;
            REG_COLOR_COUNT:     gen_colors  = clamp_count(data[COLOR_CNT_W-1:0], MAX_COLORS);
            REG_CLASS_COUNT:     gen_classes = clamp_count(data[CLASS_CNT_W-1:0], MAX_CLASSES);
            default: ;
        endcase
    endtask

    // The first count elements of one record, with random content
    task automatic push_record(input bit start, input int unsigned count);
        int unsigned e;
        int b;
        logic [DATA_W-1:0] v;
        for (e = 0; e < count; e++) begin
            if (e < KP_LEN) begin
                v = ($urandom_range(0, 7) == 0) ? DATA_W'($urandom)
                                                : DATA_W'(int'($urandom_range(0, 2048)) - 1024);
            end else if (e == KP_LEN) begin
                b = int'(gen_thr) + int'($urandom_range(0, 400));
                if (b > 32767) b = 32767;
                v = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom) : DATA_W'(b);
            end else begin
                // narrow score range so that ties are common
                v = ($urandom_range(0, 5) == 0) ? DATA_W'($urandom)
                                                : DATA_W'(int'($urandom_range(0, 40)) - 20);
            end
            push_element(v, (e == 0 && start) || $urandom_range(0, 99) == 0);
        end
    endtask

    // Driver: elements and register writes, one NBA per signal per edge
    always @(posedge aclk) begin : drive
        logic              nv, nw, nu;
        logic [DATA_W-1:0] nd, ncd;
        logic [CFG_IDX_W-1:0] nci;
        feed_t             f;
        nv  = s_tvalid;
        nd  = s_tdata;
        nu  = s_tuser;
        nw  = cfg_valid;
        nci = cfg_index;
        ncd = cfg_data;
        if (!aresetn) begin
            nv    = 1'b0;
            nw    = 1'b0;
            quiet = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_element(s_tdata, s_tuser);
                n_sent++;
                nv    = 1'b0;
                quiet = 0;
            end else if (m_tvalid) begin
                quiet = 0;
            end else if (quiet < SETTLE) begin
                quiet++;
            end
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
                nw = 1'b0;
            end
            if (!nv && !nw) begin
                if (beat_gap > 0) begin
                    beat_gap--;
                end else if (feed_q.size() > 0) begin
                    if (feed_q[0].is_write) begin
                        // registers change only once the block is quiet
                        if (proposal_q.size() == 0 && quiet >= SETTLE) begin
                            f   = feed_q.pop_front();
                            nw  = 1'b1;
                            nci = f.index;
                            ncd = f.data;
                        end
                    end else begin
                        f  = feed_q.pop_front();
                        nv = 1'b1;
                        nd = f.data;
                        nu = f.start;
                        beat_gap = pick_wait(((n_sent / 64) % 4) == 3);
                    end
                end
            end
        end
        s_tvalid  <= nv;
        s_tdata   <= nd;
        s_tuser   <= nu;
        cfg_valid <= nw;
        cfg_index <= nci;
        cfg_data  <= ncd;
    end

    // Monitor: compare each proposal beat with the oldest prediction
    always @(posedge aclk) begin : watch
        proposal_t got, want;
        int c;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(proposal_t)-1:0];
                n_seen++;
                if (proposal_q.size() == 0) begin
                    $display("%0t: proposal with none predicted, expected nothing, actual %h",
                             $time, m_tdata);
                    failures++;
                end else begin
                    want = proposal_q.pop_front();
                    for (c = 0; c < 8; c++) begin
                        if (got.corner[c] !== want.corner[c]) begin
                            $display("%0t: corner field %0d expected %0d actual %0d", $time, c,
                                     $signed(want.corner[c]), $signed(got.corner[c]));
                            failures++;
                        end
                    end
                    if (got.cls !== want.cls) begin
                        $display("%0t: class_index expected %0d actual %0d",
                                 $time, want.cls, got.cls);
                        failures++;
                    end
                    if (got.color !== want.color) begin
                        $display("%0t: color_index expected %0d actual %0d",
                                 $time, want.color, got.color);
                        failures++;
                    end
                    if (got.conf !== want.conf) begin
                        $display("%0t: confidence expected %0d actual %0d",
                                 $time, want.conf, got.conf);
                        failures++;
                    end
                    if (got.anchor !== want.anchor) begin
                        $display("%0t: anchor_index expected %0d actual %0d",
                                 $time, want.anchor, got.anchor);
                        failures++;
                    end
                end
                ready_wait = pick_wait(((n_seen / 8) % 4) == 2);
            end
            // the wait only runs down while a beat is being held off
            if (ready_wait > 0) begin
                if (m_tvalid) ready_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus build, reset, end of run
    initial begin : run
        int phase, r, n, k;
        bit start;
        logic [DATA_W-1:0] v;

        // Directed: saturating extremes, ties, lowest threshold
        push_write(REG_COLOR_COUNT, 16'd2);
        push_write(REG_CLASS_COUNT, 16'd2);
        push_write(REG_SCORE_THRESHOLD, 16'h8000);
        push_write(REG_INV_SCALE_X, 16'hFFFF);
        push_write(REG_INV_SCALE_Y, 16'h0000);
        for (k = 0; k < KP_LEN; k++) push_element(16'h7FFF, k == 0);
        push_element(16'h7FFF, 1'b0);                 // box
        push_element(16'd5, 1'b0);                    // color tie
        push_element(16'd5, 1'b0);
        push_element(16'h7FFF, 1'b0);                 // class tie at the top
        push_element(16'h7FFF, 1'b0);
        for (k = 0; k < KP_LEN; k++) push_element(16'h8000, 1'b0);
        push_element(16'h8000, 1'b0);                 // box at the threshold
        push_element(16'h8000, 1'b0);
        push_element(16'd7, 1'b0);
        push_element(16'h8000, 1'b0);
        push_element(16'h8000, 1'b0);

        // Random phases; the first four force extreme settings
        phase = 0;
        while (n_items < ITEMS) begin
            for (r = int'(REG_SCORE_THRESHOLD); r <= int'(REG_CLASS_COUNT); r++) begin
                if (phase < 4 || $urandom_range(0, 1) == 0) begin
                    case (cfg_reg_t'(r))
                        REG_SCORE_THRESHOLD: begin
                            case (phase)
                                0: v = 16'h8000;
                                1: v = 16'h7FFF;
                                default: v = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom)
                                             : DATA_W'(int'($urandom_range(0, 768)) - 512);
                            endcase
                        end
                        REG_NET_WIDTH, REG_NET_HEIGHT: begin
                            case (phase)
                                0: v = 16'd1;
                                1: v = 16'd1024;
                                2: v = 16'd0;
                                3: v = 16'd2047;
                                default: begin
                                    n = $urandom_range(0, 11);
                                    v = (n == 0) ? 16'd32 : (n == 1) ? 16'd7
                                      : (n == 2) ? DATA_W'($urandom_range(0, 2047))
                                      : DATA_W'($urandom_range(8, 48));
                                end
                            endcase
                            if ($urandom_range(0, 3) == 0) v[DATA_W-1:NET_W] = $urandom;
                        end
                        REG_INV_SCALE_X, REG_INV_SCALE_Y: begin
                            case (phase)
                                0: v = 16'h0000;
                                1: v = 16'hFFFF;
                                default: v = ($urandom_range(0, 3) == 0) ? 16'd4096
                                                                         : DATA_W'($urandom);
                            endcase
                        end
                        REG_COLOR_COUNT: begin
                            case (phase)
                                0: v = 16'd1;
                                1: v = 16'd8;
                                2: v = 16'd0;
                                3: v = 16'd15;
                                default: v = ($urandom_range(0, 5) == 0)
                                             ? DATA_W'($urandom_range(0, 15))
                                             : DATA_W'($urandom_range(1, 4));
                            endcase
                            if ($urandom_range(0, 3) == 0) v[DATA_W-1:COLOR_CNT_W] = $urandom;
                        end
                        default: begin
                            case (phase)
                                0: v = 16'd1;
                                1: v = 16'd16;
                                2: v = 16'd0;
                                3: v = 16'd31;
                                default: v = ($urandom_range(0, 5) == 0)
                                             ? DATA_W'($urandom_range(0, 31))
                                             : DATA_W'($urandom_range(1, 6));
                            endcase
                            if ($urandom_range(0, 3) == 0) v[DATA_W-1:CLASS_CNT_W] = $urandom;
                        end
                    endcase
                    push_write(cfg_reg_t'(r), v);
                end
            end

            // Mostly whole records; sometimes a phase ends inside a record
            start = ($urandom_range(0, 3) != 0);
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
                push_record(start && k == 0, KP_LEN + 1 + gen_colors + gen_classes);
            end
            if ($urandom_range(0, 4) == 0) begin
                push_record(1'b0, $urandom_range(1, KP_LEN + gen_colors + gen_classes));
            end
            phase++;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (feed_q.size() != 0 || s_tvalid || cfg_valid || proposal_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (failures == 0 && proposal_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* keypoint_proposal_decoder.f */
src/kpd_pkg.sv
src/kpd_record.sv
src/kpd_scale.sv
src/keypoint_proposal_decoder.sv
src/kpd_checker.sv
sim/keypoint_proposal_decoder_test.sv
